### rtl/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants for the button debounce and hold detector.
// ----------------------------------------------------------------------------
package bdh_pkg;

  localparam int NUM_BUTTONS_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  localparam int PIN_W      = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 3;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic             ACTIVE_RST     = 1'b0;

  // opcodes carried in tuser
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd2;

  typedef enum logic [2:0] {
    EV_PRESS        = 3'd0,
    EV_RELEASE      = 3'd1,
    EV_HOLD         = 3'd2,
    EV_LONG_RELEASE = 3'd3,
    EV_STATE        = 3'd4
  } event_code_t;

  // one entry of the per-button state memory
  typedef struct packed {
    logic             pressed;
    logic             hold_fired;
    logic [CNT_W-1:0] hold_count;
    logic [CNT_W-1:0] deb_count;
  } btn_entry_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] id;
    event_code_t      code;
    logic             pressed;
  } btn_event_t;

  typedef struct packed {
    logic start;
    logic flush;
  } rbuf_ctrl_t;

  typedef struct packed {
    logic ev_ok;
    logic pend_valid;
  } rbuf_status_t;

endpackage

### rtl/bdh_state_mem.sv
// ----------------------------------------------------------------------------
// bdh_state_mem
// Per-button state memory, one synchronous read port and one write port.
// A per-entry valid bit makes unwritten entries read as the cleared state.
// ----------------------------------------------------------------------------
module bdh_state_mem
  import bdh_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                re,
  input  logic [(NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1)-1:0] raddr,
  output btn_entry_t          rdata,
  input  logic                we,
  input  logic [(NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1)-1:0] waddr,
  input  btn_entry_t          wdata
);

  btn_entry_t             mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

### rtl/bdh_result_buf.sv
// ----------------------------------------------------------------------------
// bdh_result_buf
// Result staging: a pending slot holds the newest event until the next one
// (or the end of the word) shows whether it is the last; an output register
// feeds the master stream. Events past the per-word cap are dropped.
// ----------------------------------------------------------------------------
module bdh_result_buf
  import bdh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  rbuf_ctrl_t            ctrl,
  input  btn_event_t            ev,
  output rbuf_status_t          status,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [3:0] button_id, [4] is_pressed
  output logic [OUT_USER_W-1:0] m_axis_tuser,  // [2:0] event_code
  output logic                  m_axis_tlast
);

  localparam int RCW = $clog2(MAX_RESULTS + 1);

  logic           p_valid;
  btn_event_t     p_ev;
  logic [RCW-1:0] rcnt;
  logic           out_valid;
  btn_event_t     o_ev;
  logic           o_last;

  logic o_free;
  logic take;
  logic ev_ok;

  assign o_free = !out_valid || m_axis_tready;
  assign take   = ev.vld && (rcnt < RCW'(MAX_RESULTS));
  assign ev_ok  = !take || !p_valid || o_free;

  assign status.ev_ok      = ev_ok;
  assign status.pend_valid = p_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
      rcnt      <= '0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (take && p_valid && o_free) begin
        o_ev      <= p_ev;
        o_last    <= 1'b0;
        out_valid <= 1'b1;
      end else if (ctrl.flush && p_valid && o_free) begin
        o_ev      <= p_ev;
        o_last    <= 1'b1;
        out_valid <= 1'b1;
        p_valid   <= 1'b0;
      end
      if (take && ev_ok) begin
        p_ev    <= ev;
        p_valid <= 1'b1;
        rcnt    <= rcnt + RCW'(1);
      end
      if (ctrl.start) begin
        rcnt <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, o_ev.pressed, o_ev.id};
  assign m_axis_tuser  = o_ev.code;
  assign m_axis_tlast  = o_last;

  a_cap_held: assert property (@(posedge clk) disable iff (rst)
    rcnt <= RCW'(MAX_RESULTS))
    else $error("result count passed the per-word cap");

  a_flush_alone: assert property (@(posedge clk) disable iff (rst)
    ctrl.flush |-> !ev.vld)
    else $error("event offered while flushing");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

endmodule

### rtl/button_debounce_hold_detector.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_detector
// Debounces a bank of buttons and reports press, release, hold, long release
// and state-query results. Per-button state lives in one synchronous memory.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tuser opcode, tdata index and pins
//   m_axis    out  tvalid/tready/tlast  tuser event code, tdata id and state
//   cfg       in   cfg_we               cfg_index, cfg_wdata
//
// Edge word: memory read, then write-back. Unused opcode: taken without
// leaving idle. Query word: memory read, result, then flush, plus output
// wait. Tick word: the memory read port scans one button a cycle while no
// stall holds the scan, then the final result is flushed from the pending
// slot; a button that gives both press and hold sends its hold event alone.
// Output stalls hold the scan in place; the last result sits in the output
// register while the next word is taken. Reset clears all button state at
// once through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_debounce_hold_detector
  import bdh_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [3:0] button_index, [19:4] pin_levels
  input  logic [OP_W-1:0]       s_axis_tuser,   // [1:0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] button_id, [4] is_pressed
  output logic [OUT_USER_W-1:0] m_axis_tuser,   // [2:0] event_code
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int SW = $clog2(NUM_BUTTONS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_QUERY,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] debounce_ticks;
  logic [CNT_W-1:0] long_press_ticks;
  logic             active_level;
  logic [IDX_W-1:0] idx_q;
  logic [PIN_W-1:0] pins_q;
  logic             idx_ok_q;
  logic [SW-1:0]    a_cnt;
  logic             b_valid;
  logic [AW-1:0]    b_idx;
  logic             hold2_valid;
  logic [IDX_W-1:0] hold2_id;

  logic [IDX_W-1:0] in_idx;
  logic [PIN_W-1:0] in_pins;
  logic             in_idx_ok;
  logic             accept;

  btn_entry_t   ent;
  btn_entry_t   edge_entry;
  logic         edge_hit;
  btn_entry_t   nx;
  logic         e1_vld;
  event_code_t  e1_code;
  logic         e2_vld;
  logic         scan_lvl;
  logic         scan_act;
  logic [IDX_W-1:0] bid;
  logic         two_ev;
  logic         scan_adv;
  logic         scan_rd;

  logic         mem_re;
  logic [AW-1:0] mem_raddr;
  logic         mem_we;
  logic [AW-1:0] mem_waddr;
  btn_entry_t   mem_wdata;

  btn_event_t   ev;
  rbuf_ctrl_t   rctrl;
  rbuf_status_t rstat;

  assign in_idx    = s_axis_tdata[IDX_W-1:0];
  assign in_pins   = s_axis_tdata[IDX_W+PIN_W-1:IDX_W];
  assign in_idx_ok = (32'(in_idx) < NUM_BUTTONS);
  assign s_axis_tready = (state == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;

  // edge: arm the countdown when none runs and the raw level disagrees with the debounced one
  always_comb begin
    edge_hit   = (ent.deb_count == '0) &&
                 ((pins_q[idx_q] == active_level) != ent.pressed);
    edge_entry = ent;
    edge_entry.deb_count = (debounce_ticks == '0) ? CNT_W'(1) : debounce_ticks;
  end

  // tick: one button's countdown, resample and hold tracking
  assign bid      = IDX_W'(b_idx);
  assign scan_lvl = (32'(b_idx) < PIN_W) ? pins_q[IDX_W'(b_idx)] : 1'b0;
  assign scan_act = (scan_lvl == active_level);

  always_comb begin
    nx      = ent;
    e1_vld  = 1'b0;
    e1_code = EV_PRESS;
    e2_vld  = 1'b0;
    if (ent.deb_count != '0) begin
      nx.deb_count = ent.deb_count - CNT_W'(1);
      if (nx.deb_count == '0) begin
        if (scan_act) begin
          if (!ent.pressed) begin
            nx.pressed = 1'b1;
            e1_vld     = 1'b1;
            e1_code    = EV_PRESS;
          end
        end else if (ent.pressed) begin
          nx.pressed    = 1'b0;
          nx.hold_count = '0;
          nx.hold_fired = 1'b0;
          e1_vld        = 1'b1;
          e1_code       = ent.hold_fired ? EV_LONG_RELEASE : EV_RELEASE;
        end
      end
    end
    if (nx.pressed) begin
      if (nx.hold_count < long_press_ticks) begin
        nx.hold_count = nx.hold_count + CNT_W'(1);
      end else begin
        nx.hold_count = '0;
        if (!nx.hold_fired) begin
          nx.hold_fired = 1'b1;
          e2_vld        = 1'b1;
        end
      end
    end
  end

  assign two_ev = b_valid && e1_vld && e2_vld;

  always_comb begin
    ev         = '0;
    ev.code    = EV_PRESS;
    case (state)
      ST_QUERY: begin
        ev.vld     = 1'b1;
        ev.id      = idx_q;
        ev.code    = EV_STATE;
        ev.pressed = idx_ok_q && ent.pressed;
      end
      ST_SCAN: begin
        if (hold2_valid) begin
          ev.vld     = 1'b1;
          ev.id      = hold2_id;
          ev.code    = EV_HOLD;
          ev.pressed = 1'b1;
        end else if (b_valid && e1_vld) begin
          ev.vld     = 1'b1;
          ev.id      = bid;
          ev.code    = e1_code;
          ev.pressed = nx.pressed;
        end else if (b_valid && e2_vld) begin
          ev.vld     = 1'b1;
          ev.id      = bid;
          ev.code    = EV_HOLD;
          ev.pressed = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // a button finishes when its first event is taken; a second one follows alone
  assign scan_adv = (state == ST_SCAN) && !hold2_valid && (!b_valid || rstat.ev_ok);
  assign scan_rd  = scan_adv && (a_cnt != SW'(NUM_BUTTONS));

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = a_cnt[AW-1:0];
    if (accept) begin
      mem_re    = ((s_axis_tuser == OP_EDGE) || (s_axis_tuser == OP_QUERY)) && in_idx_ok;
      mem_raddr = AW'(in_idx);
    end else if (scan_rd) begin
      mem_re = 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = b_idx;
    mem_wdata = nx;
    if (state == ST_EDGE) begin
      mem_we    = edge_hit;
      mem_waddr = AW'(idx_q);
      mem_wdata = edge_entry;
    end else if (state == ST_SCAN) begin
      mem_we = b_valid && !hold2_valid && rstat.ev_ok;
    end
  end

  assign rctrl.start = accept;
  assign rctrl.flush = (state == ST_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      a_cnt            <= '0;
      b_valid          <= 1'b0;
      hold2_valid      <= 1'b0;
      debounce_ticks   <= DEBOUNCE_RST;
      long_press_ticks <= LONG_PRESS_RST;
      active_level     <= ACTIVE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:     debounce_ticks   <= cfg_wdata;
          REG_LONG_PRESS:   long_press_ticks <= cfg_wdata;
          REG_ACTIVE_LEVEL: active_level     <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            idx_q    <= in_idx;
            pins_q   <= in_pins;
            idx_ok_q <= in_idx_ok;
            case (s_axis_tuser)
              OP_EDGE: begin
                if (in_idx_ok) state <= ST_EDGE;
              end
              OP_QUERY: state <= ST_QUERY;
              OP_TICK: begin
                state   <= ST_SCAN;
                a_cnt   <= '0;
                b_valid <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_EDGE:  state <= ST_IDLE;
        ST_QUERY: state <= ST_FLUSH;
        ST_SCAN: begin
          if (hold2_valid) begin
            if (rstat.ev_ok) hold2_valid <= 1'b0;
          end else if (scan_adv) begin
            if (two_ev) begin
              hold2_valid <= 1'b1;
              hold2_id    <= bid;
            end
            b_valid <= scan_rd;
            if (scan_rd) begin
              b_idx <= a_cnt[AW-1:0];
              a_cnt <= a_cnt + SW'(1);
            end else if (!two_ev) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!rstat.pend_valid) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bdh_state_mem #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (ent),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  bdh_result_buf u_rbuf (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (rctrl),
    .ev            (ev),
    .status        (rstat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same button entry");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !rstat.pend_valid)
    else $error("new word taken with a result still pending");

  a_hold2_scan: assert property (@(posedge clk) disable iff (rst)
    hold2_valid |-> (state == ST_SCAN))
    else $error("second hold event outside a scan");

endmodule
